// ===== hdl/ps2_scancode_to_ascii_fifo_assert.svh =====
// Assertion macros for the scancode translator modules.
// Depends on nothing; included by the modules that check their own logic.
`ifndef PS2_SCANCODE_TO_ASCII_FIFO_ASSERT_SVH
`define PS2_SCANCODE_TO_ASCII_FIFO_ASSERT_SVH
`ifndef SYNTHESIS
// A property that must hold at every clock edge outside reset.
`define PS2SA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// An implication checked in the same cycle.
`define PS2SA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// An implication checked in the next cycle.
`define PS2SA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PS2SA_ASSERT(lbl, clk, rst, prop, msg)
`define PS2SA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define PS2SA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ===== hdl/ps2sa_pkg.sv =====
// Package for the set-1 scancode to ASCII translator: sizes, scancodes,
// the command passed from decoder to character FIFO, and the keymap ROM.
`timescale 1ns / 1ps

package ps2sa_pkg;

   // Character FIFO; it holds FIFO_DEPTH-1 characters.
   localparam int FIFO_DEPTH = 256;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   // Command queue between decoder and character FIFO.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Scancode bytes and key codes (set 1).
   localparam logic [7:0] SC_EXT_PREFIX   = 8'hE0;
   localparam logic [7:0] SC_RELEASE_MASK = 8'h80;
   localparam logic [6:0] KEY_LSHIFT      = 7'h2A;
   localparam logic [6:0] KEY_RSHIFT      = 7'h36;
   localparam logic [6:0] KEY_CTRL        = 7'h1D;
   localparam logic [6:0] KEY_ALT         = 7'h38;
   localparam logic [6:0] KEY_CAPS        = 7'h3A;
   localparam logic [6:0] KEY_NUM         = 7'h45;
   localparam logic [6:0] KEY_SCROLL      = 7'h46;
   localparam logic [6:0] KEY_PAGE_UP     = 7'h49;
   localparam logic [6:0] KEY_PAGE_DOWN   = 7'h51;

   // Codes pushed for extended PageUp and PageDown.
   localparam logic [6:0] CODE_PAGE_UP   = 7'd1;
   localparam logic [6:0] CODE_PAGE_DOWN = 7'd2;

   // What the character FIFO does for one item.
   typedef enum logic [1:0] {
      OP_NONE,
      OP_PUSH,
      OP_POP
   } ps2sa_op_type;

   // One classified item on its way to the character FIFO.
   typedef struct packed {
      ps2sa_op_type op;
      logic [6:0]   ch;
      logic [5:0]   modifiers;
      logic         led_update;
      logic [2:0]   led_value;
   } ps2sa_cmd_type;

   // Keymap ROM: lower map in the high half, upper map in the low half.
   function automatic logic [6:0] keymap_lookup(input logic [6:0] base, input logic upper);
      logic [13:0] pair;
      unique case (base)
         7'h01: pair = {7'h1B, 7'h1B};
         7'h02: pair = {7'h31, 7'h21};
         7'h03: pair = {7'h32, 7'h40};
         7'h04: pair = {7'h33, 7'h23};
         7'h05: pair = {7'h34, 7'h24};
         7'h06: pair = {7'h35, 7'h25};
         7'h07: pair = {7'h36, 7'h5E};
         7'h08: pair = {7'h37, 7'h26};
         7'h09: pair = {7'h38, 7'h2A};
         7'h0A: pair = {7'h39, 7'h28};
         7'h0B: pair = {7'h30, 7'h29};
         7'h0C: pair = {7'h2D, 7'h5F};
         7'h0D: pair = {7'h3D, 7'h2B};
         7'h0E: pair = {7'h08, 7'h08};
         7'h0F: pair = {7'h09, 7'h09};
         7'h10: pair = {7'h71, 7'h51};
         7'h11: pair = {7'h77, 7'h57};
         7'h12: pair = {7'h65, 7'h45};
         7'h13: pair = {7'h72, 7'h52};
         7'h14: pair = {7'h74, 7'h54};
         7'h15: pair = {7'h79, 7'h59};
         7'h16: pair = {7'h75, 7'h55};
         7'h17: pair = {7'h69, 7'h49};
         7'h18: pair = {7'h6F, 7'h4F};
         7'h19: pair = {7'h70, 7'h50};
         7'h1A: pair = {7'h5B, 7'h7B};
         7'h1B: pair = {7'h5D, 7'h7D};
         7'h1C: pair = {7'h0A, 7'h0A};
         7'h1E: pair = {7'h61, 7'h41};
         7'h1F: pair = {7'h73, 7'h53};
         7'h20: pair = {7'h64, 7'h44};
         7'h21: pair = {7'h66, 7'h46};
         7'h22: pair = {7'h67, 7'h47};
         7'h23: pair = {7'h68, 7'h48};
         7'h24: pair = {7'h6A, 7'h4A};
         7'h25: pair = {7'h6B, 7'h4B};
         7'h26: pair = {7'h6C, 7'h4C};
         7'h27: pair = {7'h3B, 7'h3A};
         7'h28: pair = {7'h27, 7'h22};
         7'h29: pair = {7'h60, 7'h7E};
         7'h2B: pair = {7'h5C, 7'h7C};
         7'h2C: pair = {7'h7A, 7'h5A};
         7'h2D: pair = {7'h78, 7'h58};
         7'h2E: pair = {7'h63, 7'h43};
         7'h2F: pair = {7'h76, 7'h56};
         7'h30: pair = {7'h62, 7'h42};
         7'h31: pair = {7'h6E, 7'h4E};
         7'h32: pair = {7'h6D, 7'h4D};
         7'h33: pair = {7'h2C, 7'h3C};
         7'h34: pair = {7'h2E, 7'h3E};
         7'h35: pair = {7'h2F, 7'h3F};
         7'h37: pair = {7'h2A, 7'h2A};
         7'h39: pair = {7'h20, 7'h20};
         7'h4A: pair = {7'h2D, 7'h2D};
         7'h4E: pair = {7'h2B, 7'h2B};
         default: pair = '0;
      endcase
      return upper ? pair[6:0] : pair[13:7];
   endfunction

endpackage

// ===== hdl/ps2_scancode_to_ascii_fifo.sv =====
// Top level of the set-1 scancode to ASCII translator with character FIFO.
// Depends on ps2sa_pkg, ps2sa_front, ps2sa_queue and ps2sa_back.
`timescale 1ns / 1ps

// Each request item either delivers one set-1 scancode byte (tuser 0) or
// pops one character (tuser 1), and gives exactly one response item in
// order. The block takes one item per clock cycle while the command queue
// has room: the decoder classifies it in the cycle it is accepted, a
// two-entry command queue follows, and the character FIFO carries out at
// most one push or pop per cycle on its single memory port. Responses
// are registered. The FIFO holds 255 characters (one slot stays free);
// a character that finds it full is dropped, and a pop on an empty FIFO
// returns zero with char_valid low. No clearing pass is needed after reset.
module ps2_scancode_to_ascii_fifo (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] scan_byte
   input  logic        req_tuser,   // [0] func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [6:0] char_out, [7] char_valid, [8] has_char, [14:9] modifiers,
   // [15] led_update, [18:16] led_value, [23:19] zero
   output logic [23:0] rsp_tdata
);

   ps2sa_pkg::ps2sa_cmd_type front_cmd, back_cmd;
   logic front_valid, front_ready, back_valid, back_ready;
   logic [6:0] char_out;
   logic       char_valid, has_char, led_update;
   logic [5:0] modifiers;
   logic [2:0] led_value;

   // Decoder and modifier state.
   ps2sa_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_func   (req_tuser),
      .in_scan   (req_tdata),
      .cmd_valid (front_valid),
      .cmd_ready (front_ready),
      .cmd       (front_cmd)
   );

   // Command queue.
   ps2sa_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (front_valid),
      .wr_ready (front_ready),
      .wr_cmd   (front_cmd),
      .rd_valid (back_valid),
      .rd_ready (back_ready),
      .rd_cmd   (back_cmd)
   );

   // Character FIFO and result register.
   ps2sa_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (back_valid),
      .cmd_ready  (back_ready),
      .cmd        (back_cmd),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .char_out   (char_out),
      .char_valid (char_valid),
      .has_char   (has_char),
      .modifiers  (modifiers),
      .led_update (led_update),
      .led_value  (led_value)
   );

   assign rsp_tdata = {5'b00000, led_value, led_update, modifiers, has_char, char_valid,
                       char_out};

endmodule

// ===== hdl/ps2sa_front.sv =====
// Decoder: accepts scancode and pop items, tracks prefix, modifier and lock
// state, and turns each item into a command. Depends on ps2sa_pkg.
`timescale 1ns / 1ps

module ps2sa_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  logic                    in_func,
   input  logic [7:0]              in_scan,
   output logic                    cmd_valid,
   input  logic                    cmd_ready,
   output ps2sa_pkg::ps2sa_cmd_type cmd
);

   logic ext_ff, shift_ff, ctrl_ff, alt_ff, caps_ff, num_ff, scroll_ff;
   logic ext_in, shift_in, ctrl_in, alt_in, caps_in, num_in, scroll_in;
   logic press;
   logic [6:0] base;
   logic [6:0] look;
   logic accept;

   assign in_ready  = cmd_ready;
   assign cmd_valid = in_valid;
   assign accept    = in_valid && in_ready;
   assign press     = (in_scan & ps2sa_pkg::SC_RELEASE_MASK) == 8'h00;
   assign base      = in_scan[6:0];

   // Classify the item and work out the state it leaves behind.
   always_comb begin
      ext_in         = ext_ff;
      shift_in       = shift_ff;
      ctrl_in        = ctrl_ff;
      alt_in         = alt_ff;
      caps_in        = caps_ff;
      num_in         = num_ff;
      scroll_in      = scroll_ff;
      look           = '0;
      cmd.op         = ps2sa_pkg::OP_NONE;
      cmd.ch         = '0;
      cmd.led_update = 1'b0;
      if (in_func) begin
         cmd.op = ps2sa_pkg::OP_POP;
      end else if (in_scan == ps2sa_pkg::SC_EXT_PREFIX) begin
         ext_in = 1'b1;
      end else if (ext_ff) begin
         // Extended keys: right alt, PageUp and PageDown only.
         ext_in = 1'b0;
         if (base == ps2sa_pkg::KEY_ALT) begin
            alt_in = press;
         end else if (press && base == ps2sa_pkg::KEY_PAGE_UP) begin
            cmd.op = ps2sa_pkg::OP_PUSH;
            cmd.ch = ps2sa_pkg::CODE_PAGE_UP;
         end else if (press && base == ps2sa_pkg::KEY_PAGE_DOWN) begin
            cmd.op = ps2sa_pkg::OP_PUSH;
            cmd.ch = ps2sa_pkg::CODE_PAGE_DOWN;
         end
      end else begin
         ext_in = 1'b0;
         unique case (base)
            ps2sa_pkg::KEY_LSHIFT, ps2sa_pkg::KEY_RSHIFT: shift_in = press;
            ps2sa_pkg::KEY_CTRL: ctrl_in = press;
            ps2sa_pkg::KEY_ALT:  alt_in  = press;
            ps2sa_pkg::KEY_CAPS: begin
               if (!press) begin
                  caps_in        = !caps_ff;
                  cmd.led_update = 1'b1;
               end
            end
            ps2sa_pkg::KEY_NUM: begin
               if (!press) begin
                  num_in         = !num_ff;
                  cmd.led_update = 1'b1;
               end
            end
            ps2sa_pkg::KEY_SCROLL: begin
               if (!press) begin
                  scroll_in      = !scroll_ff;
                  cmd.led_update = 1'b1;
               end
            end
            default: ;
         endcase
         // Lock toggles happen on release only, so they never push.
         look = ps2sa_pkg::keymap_lookup(base, shift_in ^ caps_in);
         if (press && look != 7'd0) begin
            cmd.op = ps2sa_pkg::OP_PUSH;
            cmd.ch = look;
         end
      end
      cmd.modifiers = {scroll_in, num_in, caps_in, alt_in, ctrl_in, shift_in};
      cmd.led_value = {caps_in, num_in, scroll_in};
   end

   // Prefix, modifier and lock state.
   always_ff @(posedge clock) begin
      if (reset) begin
         ext_ff    <= 1'b0;
         shift_ff  <= 1'b0;
         ctrl_ff   <= 1'b0;
         alt_ff    <= 1'b0;
         caps_ff   <= 1'b0;
         num_ff    <= 1'b1;
         scroll_ff <= 1'b0;
      end else if (accept) begin
         ext_ff    <= ext_in;
         shift_ff  <= shift_in;
         ctrl_ff   <= ctrl_in;
         alt_ff    <= alt_in;
         caps_ff   <= caps_in;
         num_ff    <= num_in;
         scroll_ff <= scroll_in;
      end
   end

endmodule

// ===== hdl/ps2sa_queue.sv =====
// Short command queue that decouples the decoder from the character FIFO.
// Depends on ps2sa_pkg.
`timescale 1ns / 1ps

module ps2sa_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_valid,
   output logic                     wr_ready,
   input  ps2sa_pkg::ps2sa_cmd_type wr_cmd,
   output logic                     rd_valid,
   input  logic                     rd_ready,
   output ps2sa_pkg::ps2sa_cmd_type rd_cmd
);

   ps2sa_pkg::ps2sa_cmd_type slot_ff [ps2sa_pkg::QUEUE_DEPTH];
   logic [ps2sa_pkg::QUEUE_AW-1:0] wr_idx_ff, wr_idx_in;
   logic [ps2sa_pkg::QUEUE_AW-1:0] rd_idx_ff, rd_idx_in;
   logic [ps2sa_pkg::QUEUE_CW-1:0] count_ff, count_in;
   logic do_wr, do_rd;

   assign wr_ready = count_ff != ps2sa_pkg::QUEUE_CW'(ps2sa_pkg::QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_cmd   = slot_ff[rd_idx_ff];
   assign do_wr    = wr_valid && wr_ready;
   assign do_rd    = rd_valid && rd_ready;

   // Index and occupancy update.
   always_comb begin
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_idx_in = (wr_idx_ff == ps2sa_pkg::QUEUE_AW'(ps2sa_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_idx_ff + 1'b1;
      end
      if (do_rd) begin
         rd_idx_in = (rd_idx_ff == ps2sa_pkg::QUEUE_AW'(ps2sa_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_idx_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   // Command slots hold payload only.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_idx_ff] <= wr_cmd;
      end
   end

endmodule

// ===== hdl/ps2sa_back.sv =====
// Character FIFO and result register: carries out push and pop commands
// and forms one result per command. Depends on ps2sa_pkg and the assert header.
`timescale 1ns / 1ps
`include "ps2_scancode_to_ascii_fifo_assert.svh"

module ps2sa_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     cmd_valid,
   output logic                     cmd_ready,
   input  ps2sa_pkg::ps2sa_cmd_type cmd,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [6:0]               char_out,
   output logic                     char_valid,
   output logic                     has_char,
   output logic [5:0]               modifiers,
   output logic                     led_update,
   output logic [2:0]               led_value
);

   logic [6:0] store_mem [ps2sa_pkg::FIFO_DEPTH];
   logic [ps2sa_pkg::FIFO_AW-1:0] wr_ptr_ff, wr_ptr_in, wr_next;
   logic [ps2sa_pkg::FIFO_AW-1:0] rd_ptr_ff, rd_ptr_in, rd_next;
   logic       out_valid_ff;
   logic [6:0] char_ff;
   logic       char_valid_ff, has_char_ff, led_update_ff;
   logic [5:0] modifiers_ff;
   logic [2:0] led_value_ff;
   logic execute, empty, full, do_push, do_pop;

   assign cmd_ready = !out_valid_ff || out_ready;
   assign execute   = cmd_valid && cmd_ready;
   assign wr_next   = (wr_ptr_ff == ps2sa_pkg::FIFO_AW'(ps2sa_pkg::FIFO_DEPTH - 1)) ?
                      '0 : wr_ptr_ff + 1'b1;
   assign rd_next   = (rd_ptr_ff == ps2sa_pkg::FIFO_AW'(ps2sa_pkg::FIFO_DEPTH - 1)) ?
                      '0 : rd_ptr_ff + 1'b1;
   assign empty     = rd_ptr_ff == wr_ptr_ff;
   assign full      = wr_next == rd_ptr_ff;
   assign do_push   = execute && cmd.op == ps2sa_pkg::OP_PUSH && !full;
   assign do_pop    = execute && cmd.op == ps2sa_pkg::OP_POP && !empty;

   // Pointer update; a push into a full FIFO is dropped.
   always_comb begin
      wr_ptr_in = do_push ? wr_next : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_next : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         if (execute) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Character store: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_mem[wr_ptr_ff] <= cmd.ch;
      end
      if (execute) begin
         if (do_pop) begin
            char_ff <= store_mem[rd_ptr_ff];
         end else begin
            char_ff <= '0;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (execute) begin
         char_valid_ff <= do_pop;
         has_char_ff   <= rd_ptr_in != wr_ptr_in;
         modifiers_ff  <= cmd.modifiers;
         led_update_ff <= cmd.led_update;
         led_value_ff  <= cmd.led_value;
      end
   end

   assign out_valid  = out_valid_ff;
   assign char_out   = char_ff;
   assign char_valid = char_valid_ff;
   assign has_char   = has_char_ff;
   assign modifiers  = modifiers_ff;
   assign led_update = led_update_ff;
   assign led_value  = led_value_ff;

   // Stored characters are never zero, so a real pop never returns zero.
   `PS2SA_ASSERT_IMP(a_pop_nonzero, clock, reset, out_valid_ff && char_valid_ff, char_ff != 7'd0, "pop returned a zero character")
   // The reported fill flag matches the pointers while a result waits.
   `PS2SA_ASSERT_IMP(a_has_char_match, clock, reset, out_valid_ff, has_char_ff == (rd_ptr_ff != wr_ptr_ff), "has_char disagrees with FIFO pointers")
   // A stalled result holds the FIFO still.
   `PS2SA_ASSERT_NEXT(a_stall_holds_ptrs, clock, reset, out_valid_ff && !out_ready, $stable(rd_ptr_ff) && $stable(wr_ptr_ff), "FIFO moved while result stalled")

endmodule

// ===== sim/ps2_scancode_to_ascii_fifo_tb.sv =====
// Self-checking testbench for the set-1 scancode to ASCII translator with character FIFO.
// Depends on ps2sa_pkg and ps2_scancode_to_ascii_fifo; predicts every response item itself.
`timescale 1ns / 1ps

module ps2_scancode_to_ascii_fifo_tb;

   localparam int STUCK_LIMIT = 1000;
   localparam int DRAIN_CYCLES = 10;
   localparam logic FUNC_SCAN = 1'b0;
   localparam logic FUNC_POP  = 1'b1;

   // Fields of one response item, highest bits first.
   typedef struct packed {
      logic [2:0] led_value;
      logic       led_update;
      logic [5:0] modifiers;
      logic       has_char;
      logic       char_valid;
      logic [6:0] char_out;
   } rsp_fields_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] scan_byte
   logic        req_tuser = 1'b0;    // [0] func
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // [6:0] char_out, [7] char_valid, [8] has_char, [14:9] modifiers,
   // [15] led_update, [18:16] led_value, [23:19] zero
   logic [23:0] rsp_tdata;

   // Idling on both sides is switched off for the last part of the run.
   logic           idle_on = 1'b1;
   int             stall_left = 0;
   int             stuck_cycles = 0;
   int             error_count = 0;
   rsp_fields_type want;
   rsp_fields_type got;
   rsp_fields_type predicted_rsp[$];

   // Predicted keyboard and FIFO state.
   logic                          ext_pending = 1'b0;
   logic                          shift_held = 1'b0;
   logic                          ctrl_held = 1'b0;
   logic                          alt_held = 1'b0;
   logic                          caps_on = 1'b0;
   logic                          num_on = 1'b1;
   logic                          scroll_on = 1'b0;
   logic [6:0]                    char_store [ps2sa_pkg::FIFO_DEPTH];
   logic [ps2sa_pkg::FIFO_AW-1:0] rd_ptr = '0;
   logic [ps2sa_pkg::FIFO_AW-1:0] wr_ptr = '0;

   ps2_scancode_to_ascii_fifo u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Character for a key code, from the unshifted or the shifted keymap.
   function automatic logic [6:0] key_char(input logic [6:0] code, input logic upper);
      logic [7:0] c;
      case (code)
         7'h01: c = 8'd27;
         7'h02: c = upper ? "!" : "1";
         7'h03: c = upper ? "@" : "2";
         7'h04: c = upper ? "#" : "3";
         7'h05: c = upper ? "$" : "4";
         7'h06: c = upper ? "%" : "5";
         7'h07: c = upper ? "^" : "6";
         7'h08: c = upper ? "&" : "7";
         7'h09: c = upper ? "*" : "8";
         7'h0A: c = upper ? "(" : "9";
         7'h0B: c = upper ? ")" : "0";
         7'h0C: c = upper ? "_" : "-";
         7'h0D: c = upper ? "+" : "=";
         7'h0E: c = 8'd8;
         7'h0F: c = 8'd9;
         7'h10: c = upper ? "Q" : "q";
         7'h11: c = upper ? "W" : "w";
         7'h12: c = upper ? "E" : "e";
         7'h13: c = upper ? "R" : "r";
         7'h14: c = upper ? "T" : "t";
         7'h15: c = upper ? "Y" : "y";
         7'h16: c = upper ? "U" : "u";
         7'h17: c = upper ? "I" : "i";
         7'h18: c = upper ? "O" : "o";
         7'h19: c = upper ? "P" : "p";
         7'h1A: c = upper ? "{" : "[";
         7'h1B: c = upper ? "}" : "]";
         7'h1C: c = 8'd10;
         7'h1E: c = upper ? "A" : "a";
         7'h1F: c = upper ? "S" : "s";
         7'h20: c = upper ? "D" : "d";
         7'h21: c = upper ? "F" : "f";
         7'h22: c = upper ? "G" : "g";
         7'h23: c = upper ? "H" : "h";
         7'h24: c = upper ? "J" : "j";
         7'h25: c = upper ? "K" : "k";
         7'h26: c = upper ? "L" : "l";
         7'h27: c = upper ? ":" : ";";
         7'h28: c = upper ? 8'h22 : 8'h27;
         7'h29: c = upper ? 8'h7E : 8'h60;
         7'h2B: c = upper ? 8'h7C : 8'h5C;
         7'h2C: c = upper ? "Z" : "z";
         7'h2D: c = upper ? "X" : "x";
         7'h2E: c = upper ? "C" : "c";
         7'h2F: c = upper ? "V" : "v";
         7'h30: c = upper ? "B" : "b";
         7'h31: c = upper ? "N" : "n";
         7'h32: c = upper ? "M" : "m";
         7'h33: c = upper ? "<" : ",";
         7'h34: c = upper ? ">" : ".";
         7'h35: c = upper ? "?" : "/";
         7'h37: c = "*";
         7'h39: c = " ";
         7'h4A: c = "-";
         7'h4E: c = "+";
         default: c = 8'h00;
      endcase
      return c[6:0];
   endfunction

   // Push into the predicted FIFO; one slot always stays free.
   function automatic void push_char(input logic [6:0] ch);
      if (wr_ptr + 1'b1 != rd_ptr) begin
         char_store[wr_ptr] = ch;
         wr_ptr = wr_ptr + 1'b1;
      end
   endfunction

   // Update the predicted state for one accepted item and give its response.
   function automatic rsp_fields_type translate_item(input logic func, input logic [7:0] code);
      rsp_fields_type r;
      logic           press;
      logic [6:0]     base;
      logic           ext;
      logic [6:0]     ch;
      r = '0;
      if (func == FUNC_POP) begin
         if (rd_ptr != wr_ptr) begin
            r.char_out = char_store[rd_ptr];
            r.char_valid = 1'b1;
            rd_ptr = rd_ptr + 1'b1;
         end
      end else if (code == ps2sa_pkg::SC_EXT_PREFIX) begin
         ext_pending = 1'b1;
      end else begin
         press = (code & ps2sa_pkg::SC_RELEASE_MASK) == 8'h00;
         base = code[6:0];
         ext = ext_pending;
         ext_pending = 1'b0;
         if (ext) begin
            // Extended keys: only right alt and the page keys matter.
            if (base == ps2sa_pkg::KEY_ALT) begin
               alt_held = press;
            end else if (press && base == ps2sa_pkg::KEY_PAGE_UP) begin
               push_char(ps2sa_pkg::CODE_PAGE_UP);
            end else if (press && base == ps2sa_pkg::KEY_PAGE_DOWN) begin
               push_char(ps2sa_pkg::CODE_PAGE_DOWN);
            end
         end else begin
            case (base)
               ps2sa_pkg::KEY_LSHIFT, ps2sa_pkg::KEY_RSHIFT: shift_held = press;
               ps2sa_pkg::KEY_CTRL: ctrl_held = press;
               ps2sa_pkg::KEY_ALT: alt_held = press;
               ps2sa_pkg::KEY_CAPS: if (!press) begin
                  caps_on = ~caps_on;
                  r.led_update = 1'b1;
               end
               ps2sa_pkg::KEY_NUM: if (!press) begin
                  num_on = ~num_on;
                  r.led_update = 1'b1;
               end
               ps2sa_pkg::KEY_SCROLL: if (!press) begin
                  scroll_on = ~scroll_on;
                  r.led_update = 1'b1;
               end
               default: ;
            endcase
            // A lock toggle ends the step; otherwise a press may type a character.
            if (!r.led_update) begin
               ch = key_char(base, shift_held ^ caps_on);
               if (ch != 7'd0 && press) begin
                  push_char(ch);
               end
            end
         end
      end
      r.has_char = rd_ptr != wr_ptr;
      r.modifiers = {scroll_on, num_on, caps_on, alt_held, ctrl_held, shift_held};
      r.led_value = {caps_on, num_on, scroll_on};
      return r;
   endfunction

   function automatic void check_field(input string name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_val, act_val);
         error_count++;
      end
   endfunction

   // Send one request item, with an occasional gap before it.
   task automatic send_item(input logic func, input logic [7:0] code);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= code;
      do @(posedge clock); while (!req_tready);
      predicted_rsp.push_back(translate_item(func, code));
   endtask

   task automatic send_press_release(input logic [7:0] code);
      send_item(FUNC_SCAN, code);
      send_item(FUNC_SCAN, code | ps2sa_pkg::SC_RELEASE_MASK);
   endtask

   // Response side: check each item and stall now and then.
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[18:0];
         if (predicted_rsp.size() == 0) begin
            $display("%0t: response item with none expected, expected nothing, actual %0h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want = predicted_rsp.pop_front();
            check_field("char_out", want.char_out, got.char_out);
            check_field("char_valid", want.char_valid, got.char_valid);
            check_field("has_char", want.has_char, got.has_char);
            check_field("modifiers", want.modifiers, got.modifiers);
            check_field("led_update", want.led_update, got.led_update);
            check_field("led_value", want.led_value, got.led_value);
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: work pending but no item moving on either side.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (!req_tvalid && predicted_rsp.size() == 0)) begin
         stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, stuck_cycles);
         $display("ps2_scancode_to_ascii_fifo_tb: errors");
         $finish;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
   end

   // A pop on an empty FIFO and the extreme scancode values.
   task automatic test_empty_and_extremes();
      send_item(FUNC_POP, 8'hFF);
      send_item(FUNC_SCAN, 8'h00);
      send_item(FUNC_SCAN, 8'hFF);
      send_item(FUNC_SCAN, 8'h80);
   endtask

   // Lock keys toggle on release; each lock key is released once.
   task automatic test_lock_keys();
      send_item(FUNC_SCAN, {1'b1, ps2sa_pkg::KEY_CAPS});
      send_item(FUNC_SCAN, {1'b1, ps2sa_pkg::KEY_NUM});
      send_item(FUNC_SCAN, {1'b1, ps2sa_pkg::KEY_SCROLL});
   endtask

   // Shift with caps on selects the lower map; alt follows press and release.
   task automatic test_modifiers();
      send_item(FUNC_SCAN, {1'b0, ps2sa_pkg::KEY_LSHIFT});
      send_item(FUNC_SCAN, 8'h1E);
      send_item(FUNC_SCAN, {1'b1, ps2sa_pkg::KEY_LSHIFT});
      send_press_release({1'b0, ps2sa_pkg::KEY_ALT});
   endtask

   // Double prefix, page keys, right alt, plain 0x64, byte 0xE1, then pops.
   task automatic test_extended_keys();
      send_item(FUNC_SCAN, ps2sa_pkg::SC_EXT_PREFIX);
      send_item(FUNC_SCAN, ps2sa_pkg::SC_EXT_PREFIX);
      send_item(FUNC_SCAN, {1'b0, ps2sa_pkg::KEY_PAGE_UP});
      send_item(FUNC_SCAN, ps2sa_pkg::SC_EXT_PREFIX);
      send_item(FUNC_SCAN, {1'b1, ps2sa_pkg::KEY_PAGE_DOWN});
      send_item(FUNC_SCAN, ps2sa_pkg::SC_EXT_PREFIX);
      send_item(FUNC_SCAN, {1'b0, ps2sa_pkg::KEY_ALT});
      send_item(FUNC_SCAN, ps2sa_pkg::SC_EXT_PREFIX);
      send_item(FUNC_SCAN, {1'b1, ps2sa_pkg::KEY_ALT});
      send_item(FUNC_SCAN, 8'h64);
      send_item(FUNC_SCAN, 8'hE1);
      send_item(FUNC_POP, 8'h00);
      send_item(FUNC_POP, 8'h5A);
   endtask

   // Type past the FIFO capacity, then pop it dry and beyond.
   task automatic test_fifo_full();
      repeat (270) send_item(FUNC_SCAN, 8'($urandom_range(8'h10, 8'h19)));
      repeat (260) send_item(FUNC_POP, 8'($urandom_range(0, 255)));
   endtask

   // Mostly well-formed key sequences with random content, plus noise.
   task automatic test_random_traffic(input int n_items, input int pop_pct);
      int         sent;
      int         pick;
      int         burst;
      logic [7:0] code;
      sent = 0;
      while (sent < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < pop_pct) begin
            burst = $urandom_range(1, 4);
            repeat (burst) send_item(FUNC_POP, 8'($urandom_range(0, 255)));
            sent += burst;
         end else if (pick < pop_pct + (100 - pop_pct) / 2) begin
            // Typing: press a key, and in half of the cases release it too.
            code = ($urandom_range(0, 9) == 0) ? (($urandom_range(0, 1) == 1) ? 8'h4A : 8'h4E)
                                               : 8'($urandom_range(1, 8'h39));
            send_item(FUNC_SCAN, code);
            sent++;
            if ($urandom_range(0, 1) == 1) begin
               send_item(FUNC_SCAN, code | ps2sa_pkg::SC_RELEASE_MASK);
               sent++;
            end
         end else begin
            case ($urandom_range(0, 5))
               0: begin
                  case ($urandom_range(0, 3))
                     0: code = {1'b0, ps2sa_pkg::KEY_LSHIFT};
                     1: code = {1'b0, ps2sa_pkg::KEY_RSHIFT};
                     2: code = {1'b0, ps2sa_pkg::KEY_CTRL};
                     default: code = {1'b0, ps2sa_pkg::KEY_ALT};
                  endcase
                  if ($urandom_range(0, 1) == 1) code = code | ps2sa_pkg::SC_RELEASE_MASK;
                  send_item(FUNC_SCAN, code);
                  sent++;
               end
               1: begin
                  case ($urandom_range(0, 2))
                     0: code = {1'b0, ps2sa_pkg::KEY_CAPS};
                     1: code = {1'b0, ps2sa_pkg::KEY_NUM};
                     default: code = {1'b0, ps2sa_pkg::KEY_SCROLL};
                  endcase
                  send_press_release(code);
                  sent += 2;
               end
               2, 3: begin
                  // Extended sequence, sometimes with a repeated prefix.
                  send_item(FUNC_SCAN, ps2sa_pkg::SC_EXT_PREFIX);
                  sent++;
                  if ($urandom_range(0, 3) == 0) begin
                     send_item(FUNC_SCAN, ps2sa_pkg::SC_EXT_PREFIX);
                     sent++;
                  end
                  case ($urandom_range(0, 6))
                     0: code = {1'b0, ps2sa_pkg::KEY_ALT};
                     1: code = {1'b1, ps2sa_pkg::KEY_ALT};
                     2: code = {1'b0, ps2sa_pkg::KEY_PAGE_UP};
                     3: code = {1'b0, ps2sa_pkg::KEY_PAGE_DOWN};
                     4: code = {1'b1, ps2sa_pkg::KEY_PAGE_UP};
                     5: code = {1'b1, ps2sa_pkg::KEY_PAGE_DOWN};
                     default: code = 8'($urandom_range(0, 255));
                  endcase
                  send_item(FUNC_SCAN, code);
                  sent++;
               end
               default: begin
                  send_item(FUNC_SCAN, 8'($urandom_range(0, 255)));
                  sent++;
               end
            endcase
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_empty_and_extremes();
      test_lock_keys();
      test_modifiers();
      test_extended_keys();
      test_fifo_full();
      test_random_traffic(400, 10);
      test_random_traffic(400, 55);
      test_random_traffic(300, 30);
      idle_on = 1'b0;
      test_random_traffic(150, 30);
      req_tvalid <= 1'b0;
      while (predicted_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ps2_scancode_to_ascii_fifo_tb: clean");
      end else begin
         $display("ps2_scancode_to_ascii_fifo_tb: errors");
      end
      $finish;
   end

endmodule
